// ===== sv/mcpb_pkg.sv =====
package mcpb_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int REPORTED = (CHANNELS < 8) ? CHANNELS : 8;

	// Channel count and report count in widths that compare against indexes.
	localparam logic [6:0] CHAN_L = 7'(CHANNELS);
	localparam logic [CH_W:0] REP_L = (CH_W + 1)'(REPORTED);

	localparam logic [15:0] DEFAULT_PERIOD_MS = 16'd500;
	localparam logic [15:0] DEFAULT_ON_MS = DEFAULT_PERIOD_MS / 2;
	localparam logic [9:0] DEFAULT_TICK_MS = 10'd10;

	typedef enum logic [2:0] {
		KIND_TICK = 3'd0,
		KIND_SET = 3'd1,
		KIND_START = 3'd2,
		KIND_STOP = 3'd3,
		KIND_CONFIG = 3'd4
	} kind_t;

	// One channel record as kept in the channel memory. The low-phase length
	// is stored directly so a tick does not need to subtract it out.
	typedef struct packed {
		logic steady;
		logic pin;
		logic phase_high;
		logic [15:0] pulses;
		logic [31:0] phase_start;
		logic [15:0] high_ms;
		logic [15:0] low_ms;
	} chan_rec_t;

	localparam int REC_W = $bits(chan_rec_t);

	localparam chan_rec_t RESET_REC = '{
		steady: 1'b0,
		pin: 1'b0,
		phase_high: 1'b0,
		pulses: 16'd0,
		phase_start: 32'd0,
		high_ms: DEFAULT_ON_MS,
		low_ms: DEFAULT_PERIOD_MS - DEFAULT_ON_MS
	};

	// Moves one channel forward to the time now.
	function automatic chan_rec_t advance(chan_rec_t rec, logic [31:0] now);
		chan_rec_t r;
		logic [15:0] dur;
		logic [15:0] dec;
		r = rec;
		dur = rec.phase_high ? rec.high_ms : rec.low_ms;
		dec = rec.pulses - 16'd1;
		if (rec.pulses != 16'd0 && (now - rec.phase_start) >= {16'd0, dur}) begin
			r.phase_start = now;
			if (!rec.phase_high && !rec.pulses[15] && dec == 16'd0) begin
				r.pulses = dec;
				r.pin = rec.steady;
			end else begin
				if (!rec.phase_high && !rec.pulses[15]) begin
					r.pulses = dec;
				end
				r.phase_high = !rec.phase_high;
				r.pin = !rec.phase_high;
			end
		end
		return r;
	endfunction

endpackage

// ===== sv/mcpb_ram.sv =====
module mcpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/multi_channel_pulse_blinker_top.sv =====
// Channel   Signals                                                   Handshake
// request   start, kind, channel, level, pulse_total, period_ms,      start & !busy
//           on_time_ms
// result    out_channel, pin_level, pulsing, status, last             done, one cycle
// config    cfg_data                                                  cfg_valid & cfg_ready
//
// A non-tick request reads its record into the memory's read register; its result is
// then registered with done. A tick reads the memory once per cycle and writes
// each record back the cycle after its read, so results stream one per cycle.
// Reset clears time and the per-channel valid bits and restores the default tick
// period; records that were never written read as their default values.
// Results cannot be stalled.
module multi_channel_pulse_blinker_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] kind,
	input logic [2:0] channel,
	input logic level,
	input logic signed [15:0] pulse_total,
	input logic [15:0] period_ms,
	input logic [15:0] on_time_ms,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [9:0] cfg_data,
	output logic done,
	output logic [2:0] out_channel,
	output logic pin_level,
	output logic pulsing,
	output logic status,
	output logic last
);

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} state_t;

	state_t state_q;
	logic accept;
	logic [9:0] tick_ms_q;
	logic [31:0] time_q;
	logic [2:0] kind_q;
	logic [2:0] chan_q;
	logic level_q;
	logic [15:0] count_q;
	logic [15:0] period_q;
	logic [15:0] on_q;
	logic [mcpb_pkg::CH_W-1:0] rd_idx_q;
	logic [mcpb_pkg::CHANNELS-1:0] valid_q;

	logic vld_s1;
	logic present_s1;
	logic [mcpb_pkg::CH_W-1:0] idx_s1;

	logic [mcpb_pkg::CH_W-1:0] raddr;
	logic [mcpb_pkg::REC_W-1:0] rdata;
	logic we;
	mcpb_pkg::chan_rec_t cur_rec;
	mcpb_pkg::chan_rec_t new_rec;
	logic new_status;
	logic report;
	logic report_last;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE) || vld_s1;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (state_q == ST_SWEEP) begin
			raddr = rd_idx_q;
		end else if (kind == mcpb_pkg::KIND_TICK) begin
			raddr = '0;
		end else begin
			raddr = mcpb_pkg::CH_W'(channel);
		end
	end

	mcpb_ram #(
		.WIDTH(mcpb_pkg::REC_W),
		.DEPTH(mcpb_pkg::CHANNELS)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(idx_s1),
		.wdata(new_rec),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Read, modify and write back one channel record.
	always_comb begin
		cur_rec = valid_q[idx_s1] ? mcpb_pkg::chan_rec_t'(rdata) : mcpb_pkg::RESET_REC;
		new_rec = cur_rec;
		new_status = 1'b0;
		case (kind_q)
			mcpb_pkg::KIND_TICK: begin
				new_rec = mcpb_pkg::advance(cur_rec, time_q);
			end
			mcpb_pkg::KIND_SET: begin
				if (cur_rec.pulses == 16'd0) begin
					new_rec.pin = level_q;
				end
				new_rec.steady = level_q;
			end
			mcpb_pkg::KIND_START: begin
				new_rec.pulses = count_q;
				new_rec.phase_high = 1'b1;
				new_rec.phase_start = time_q;
				new_rec.pin = 1'b1;
			end
			mcpb_pkg::KIND_STOP: begin
				new_rec.pulses = 16'd0;
				new_rec.pin = cur_rec.steady;
			end
			mcpb_pkg::KIND_CONFIG: begin
				if (on_q != 16'd0 && on_q < period_q) begin
					new_rec.high_ms = on_q;
					new_rec.low_ms = period_q - on_q;
				end else begin
					new_status = 1'b1;
				end
			end
			default: begin
				new_rec = cur_rec;
			end
		endcase
	end

	assign we = vld_s1 && present_s1;

	always_comb begin
		if (kind_q == mcpb_pkg::KIND_TICK) begin
			report = {1'b0, idx_s1} < mcpb_pkg::REP_L;
			report_last = {1'b0, idx_s1} == (mcpb_pkg::REP_L - 1'b1);
		end else begin
			report = 1'b1;
			report_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_ms_q <= mcpb_pkg::DEFAULT_TICK_MS;
			time_q <= 32'd0;
			valid_q <= '0;
			vld_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tick_ms_q <= cfg_data;
			end
			vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						vld_s1 <= 1'b1;
						if (kind == mcpb_pkg::KIND_TICK) begin
							time_q <= time_q + {22'd0, tick_ms_q};
							if (mcpb_pkg::CHANNELS > 1) begin
								state_q <= ST_SWEEP;
							end
						end
					end
				end
				ST_SWEEP: begin
					vld_s1 <= 1'b1;
					if (rd_idx_q == mcpb_pkg::CH_W'(mcpb_pkg::CHANNELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (we) begin
				valid_q[idx_s1] <= 1'b1;
			end
			done <= vld_s1 && report;
		end
	end

	// Payload registers: request fields, sweep index, stage 1 tags and result.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			chan_q <= channel;
			level_q <= level;
			count_q <= pulse_total;
			period_q <= period_ms;
			on_q <= on_time_ms;
			rd_idx_q <= mcpb_pkg::CH_W'(1);
			idx_s1 <= raddr;
			present_s1 <= (kind == mcpb_pkg::KIND_TICK) || ({4'd0, channel} < mcpb_pkg::CHAN_L);
		end else if (state_q == ST_SWEEP) begin
			rd_idx_q <= rd_idx_q + 1'b1;
			idx_s1 <= rd_idx_q;
		end
		if (kind_q == mcpb_pkg::KIND_TICK) begin
			out_channel <= 3'(idx_s1);
		end else begin
			out_channel <= chan_q;
		end
		pin_level <= present_s1 && new_rec.pin;
		pulsing <= present_s1 && (new_rec.pulses != 16'd0);
		status <= present_s1 && new_status;
		last <= report_last;
	end

	// The sweep keeps the memory pipeline full until the last channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |=> vld_s1)
		else $error("sweep left a gap in the read pipeline");

	// Results of one request come back to back, ending with last.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |=> done)
		else $error("result stream broke before last");

	// A newly accepted request never sees a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !done)
		else $error("result appeared one cycle after acceptance");

	// Only a rejected timing configuration reports a nonzero status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (kind_q == mcpb_pkg::KIND_CONFIG))
		else $error("status set on a request other than configure");

endmodule

// ===== bench/multi_channel_pulse_blinker_top_tb.sv =====
module multi_channel_pulse_blinker_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 22;
	localparam int DRAIN_CYCLES = mcpb_pkg::CHANNELS + 4;

	// Kind codes that the block must treat as no-ops.
	localparam logic [2:0] KIND_RSVD_5 = 3'd5;
	localparam logic [2:0] KIND_RSVD_6 = 3'd6;
	localparam logic [2:0] KIND_RSVD_7 = 3'd7;

	typedef struct {
		logic [2:0] kind;
		logic [2:0] ch;
		logic lv;
		logic [15:0] pulses;
		logic [15:0] per;
		logic [15:0] on_ms;
		bit typed;
		bit t_pin;
		bit t_pulsing;
		bit t_status;
	} blink_req_t;

	typedef struct packed {
		logic [2:0] ch;
		logic pin;
		logic pulsing;
		logic status;
		logic last;
	} blink_res_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] kind;
	logic [2:0] channel;
	logic level;
	logic signed [15:0] pulse_total;
	logic [15:0] period_ms;
	logic [15:0] on_time_ms;
	logic cfg_valid;
	logic cfg_ready;
	logic [9:0] cfg_data;
	logic done;
	logic [2:0] out_channel;
	logic pin_level;
	logic pulsing;
	logic status;
	logic last;

	// Mirror of the block state.
	logic [31:0] ms_now;
	logic [9:0] tick_ms;
	logic ch_steady [mcpb_pkg::CHANNELS];
	logic ch_pin [mcpb_pkg::CHANNELS];
	logic ch_phase_high [mcpb_pkg::CHANNELS];
	logic [15:0] ch_left [mcpb_pkg::CHANNELS];
	logic [31:0] ch_phase_start [mcpb_pkg::CHANNELS];
	logic [15:0] ch_period [mcpb_pkg::CHANNELS];
	logic [15:0] ch_on [mcpb_pkg::CHANNELS];

	blink_res_t pin_report_q [$];
	blink_res_t exp_res;
	int n_errors = 0;
	int stall_cycles = 0;

	// Typed expectations only where they are obvious: timing configurations, pin levels
	// right after set, start and stop.
	blink_req_t dir_rows [25] = '{
		'{mcpb_pkg::KIND_CONFIG, 3'd0, 1'b0, 16'h0000, 16'd100, 16'd0, 1'b1, 1'b0, 1'b0, 1'b1},
		'{mcpb_pkg::KIND_CONFIG, 3'd1, 1'b0, 16'h0000, 16'd100, 16'd100, 1'b1, 1'b0, 1'b0, 1'b1},
		'{mcpb_pkg::KIND_CONFIG, 3'd2, 1'b1, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1},
		'{mcpb_pkg::KIND_CONFIG, 3'd0, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFE, 1'b1, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_CONFIG, 3'd1, 1'b0, 16'h0000, 16'd20, 16'd10, 1'b1, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_CONFIG, 3'd2, 1'b0, 16'h0000, 16'd30, 16'd20, 1'b0, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_SET, 3'd3, 1'b1, 16'h0000, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_START, 3'd3, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_SET, 3'd3, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_START, 3'd1, 1'b0, 16'd2, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0},
		'{mcpb_pkg::KIND_START, 3'd2, 1'b0, 16'hFFFF, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0},
		'{mcpb_pkg::KIND_START, 3'd7, 1'b0, 16'h7FFF, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0},
		'{mcpb_pkg::KIND_START, 3'd6, 1'b0, 16'h8000, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0},
		'{mcpb_pkg::KIND_SET, 3'd1, 1'b1, 16'h0000, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_TICK, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_TICK, 3'd0, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_TICK, 3'd0, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_TICK, 3'd0, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_STOP, 3'd6, 1'b1, 16'h0000, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{KIND_RSVD_5, 3'd4, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_RSVD_7, 3'd5, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_RSVD_6, 3'd0, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_TICK, 3'd0, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_STOP, 3'd7, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{mcpb_pkg::KIND_TICK, 3'd0, 1'b0, 16'h0000, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0}
	};

	multi_channel_pulse_blinker_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.channel(channel),
		.level(level),
		.pulse_total(pulse_total),
		.period_ms(period_ms),
		.on_time_ms(on_time_ms),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.out_channel(out_channel),
		.pin_level(pin_level),
		.pulsing(pulsing),
		.status(status),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic void advance_pulse_train(int c);
		logic [15:0] dur;
		if (ch_left[c] != 16'd0) begin
			dur = ch_phase_high[c] ? ch_on[c] : 16'(ch_period[c] - ch_on[c]);
			if ((ms_now - ch_phase_start[c]) >= {16'd0, dur}) begin
				ch_phase_start[c] = ms_now;
				// Only a finite train counts down, once per completed low phase.
				if (!ch_phase_high[c] && !ch_left[c][15])
					ch_left[c] = ch_left[c] - 16'd1;
				if (ch_left[c] == 16'd0) begin
					ch_pin[c] = ch_steady[c];
				end else begin
					ch_phase_high[c] = !ch_phase_high[c];
					ch_pin[c] = ch_phase_high[c];
				end
			end
		end
	endfunction

	function automatic void report_channel(int c, bit st, bit lst);
		blink_res_t res;
		res.ch = 3'(c);
		res.pin = (c < mcpb_pkg::CHANNELS) ? ch_pin[c] : 1'b0;
		res.pulsing = (c < mcpb_pkg::CHANNELS) ? (ch_left[c] != 16'd0) : 1'b0;
		res.status = st;
		res.last = lst;
		pin_report_q.push_back(res);
	endfunction

	function automatic void predict_pin_reports(blink_req_t r);
		int c;
		bit st;
		c = int'(r.ch);
		st = 1'b0;
		if (r.kind == mcpb_pkg::KIND_TICK) begin
			ms_now = ms_now + {22'd0, tick_ms};
			for (int i = 0; i < mcpb_pkg::CHANNELS; i++)
				advance_pulse_train(i);
			for (int i = 0; i < mcpb_pkg::REPORTED; i++)
				report_channel(i, 1'b0, i == mcpb_pkg::REPORTED - 1);
		end else if (c >= mcpb_pkg::CHANNELS) begin
			report_channel(c, 1'b0, 1'b1);
		end else begin
			case (r.kind)
				mcpb_pkg::KIND_SET: begin
					if (ch_left[c] == 16'd0)
						ch_pin[c] = r.lv;
					ch_steady[c] = r.lv;
				end
				mcpb_pkg::KIND_START: begin
					ch_left[c] = r.pulses;
					ch_phase_high[c] = 1'b1;
					ch_phase_start[c] = ms_now;
					ch_pin[c] = 1'b1;
				end
				mcpb_pkg::KIND_STOP: begin
					ch_left[c] = 16'd0;
					ch_pin[c] = ch_steady[c];
				end
				mcpb_pkg::KIND_CONFIG: begin
					if (r.on_ms != 16'd0 && r.on_ms < r.per) begin
						ch_period[c] = r.per;
						ch_on[c] = r.on_ms;
					end else begin
						st = 1'b1;
					end
				end
				default: begin
				end
			endcase
			report_channel(c, st, 1'b1);
		end
	endfunction

	function automatic blink_req_t random_request();
		blink_req_t r;
		int pick;
		int sub;
		pick = $urandom_range(99);
		sub = $urandom_range(99);
		r.ch = 3'($urandom);
		r.lv = 1'($urandom);
		r.pulses = 16'($urandom);
		r.per = 16'($urandom);
		r.on_ms = 16'($urandom);
		r.typed = 1'b0;
		r.t_pin = 1'b0;
		r.t_pulsing = 1'b0;
		r.t_status = 1'b0;
		if (pick < 40) begin
			r.kind = mcpb_pkg::KIND_TICK;
		end else if (pick < 58) begin
			r.kind = mcpb_pkg::KIND_START;
			// Mostly short trains so that they run to completion within the run.
			if (sub < 60)
				r.pulses = 16'($urandom_range(1, 4));
			else if (sub < 75)
				r.pulses = {1'b1, 15'($urandom)};
			else if (sub < 85)
				r.pulses = 16'd0;
		end else if (pick < 72) begin
			r.kind = mcpb_pkg::KIND_CONFIG;
			if (sub < 60) begin
				r.per = 16'($urandom_range(2, 60));
				r.on_ms = 16'($urandom_range(1, int'(r.per) - 1));
			end else if (sub < 75) begin
				r.per = 16'($urandom_range(0, 60));
				r.on_ms = sub[0] ? 16'd0 : r.per + 16'($urandom_range(0, 3));
			end
		end else if (pick < 84) begin
			r.kind = mcpb_pkg::KIND_SET;
		end else if (pick < 94) begin
			r.kind = mcpb_pkg::KIND_STOP;
		end else begin
			case ($urandom_range(2))
				0: r.kind = KIND_RSVD_5;
				1: r.kind = KIND_RSVD_6;
				default: r.kind = KIND_RSVD_7;
			endcase
		end
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance with
	// start still high, so the next request can follow back to back.
	task automatic send_request(blink_req_t r, int idle_pct);
		int n;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		kind = r.kind;
		channel = r.ch;
		level = r.lv;
		pulse_total = r.pulses;
		period_ms = r.per;
		on_time_ms = r.on_ms;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		predict_pin_reports(r);
		if (r.typed) begin
			n = pin_report_q.size() - 1;
			pin_report_q[n].pin = r.t_pin;
			pin_report_q[n].pulsing = r.t_pulsing;
			pin_report_q[n].status = r.t_status;
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (pin_report_q.size() != 0 || busy)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_tick_period(logic [9:0] v);
		cfg_data = v;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		tick_ms = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic void check_field(string name, int expv, int actv);
		if (expv != actv) begin
			n_errors++;
			$error("%s: expected %0d, got %0d", name, expv, actv);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pin_report_q.size() == 0) begin
				n_errors++;
				$error("out_channel: expected no result, got %0d", out_channel);
			end else begin
				exp_res = pin_report_q.pop_front();
				check_field("out_channel", exp_res.ch, out_channel);
				check_field("pin_level", exp_res.pin, pin_level);
				check_field("pulsing", exp_res.pulsing, pulsing);
				check_field("status", exp_res.status, status);
				check_field("last", exp_res.last, last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int idle_pct [4];
		logic [9:0] phase_tick [4];
		arst_n = 1'b0;
		start = 1'b0;
		kind = mcpb_pkg::KIND_TICK;
		channel = 3'd0;
		level = 1'b0;
		pulse_total = 16'sd0;
		period_ms = 16'd0;
		on_time_ms = 16'd0;
		cfg_valid = 1'b0;
		cfg_data = 10'd0;
		ms_now = 32'd0;
		tick_ms = mcpb_pkg::DEFAULT_TICK_MS;
		for (int c = 0; c < mcpb_pkg::CHANNELS; c++) begin
			ch_steady[c] = 1'b0;
			ch_pin[c] = 1'b0;
			ch_phase_high[c] = 1'b0;
			ch_left[c] = 16'd0;
			ch_phase_start[c] = 32'd0;
			ch_period[c] = mcpb_pkg::DEFAULT_PERIOD_MS;
			ch_on[c] = mcpb_pkg::DEFAULT_ON_MS;
		end
		idle_pct = '{0, 62, 0, 30};
		phase_tick = '{10'd1, 10'd1000, 10'($urandom_range(2, 999)), 10'd5};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The directed rows run with the tick period left at its reset value.
		foreach (dir_rows[i])
			send_request(dir_rows[i], 0);

		for (int p = 0; p < 4; p++) begin
			wait_drained();
			write_tick_period(phase_tick[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2)
					wait_drained();
				send_request(random_request(), idle_pct[p]);
			end
		end

		wait_drained();
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
